@@ rtl/wsd_pkg.sv @@
// types and constants shared by the websocket frame deframer
package wsd_pkg;

	// length codes in header byte one
	localparam logic [6:0] LEN16_CODE = 7'd126;
	localparam logic [6:0] LEN64_CODE = 7'd127;

	// byte counts of the extended length and mask key fields
	localparam logic [3:0] LEN16_BYTES = 4'd2;
	localparam logic [3:0] LEN64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	localparam int MAXLEN_W = 63;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TRUNC    = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       buffer_end;
	} wsd_in_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       data_valid;
		logic [3:0] frame_opcode;
		logic       frame_fin;
		logic       frame_masked;
		logic       frame_end;
		logic [1:0] status;
	} wsd_out_t;

endpackage

@@ rtl/wsd_parser.sv @@
// frame parse state and the per-byte step logic
module wsd_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_en,
	input  wsd_pkg::wsd_in_t      in_word,
	input  logic [62:0]           max_len,
	output wsd_pkg::wsd_out_t     res,
	output logic                  emit
);
	import wsd_pkg::*;

	typedef enum logic [6:0] {
		PH_HDR0  = 7'b0000001,
		PH_HDR1  = 7'b0000010,
		PH_EXT16 = 7'b0000100,
		PH_EXT64 = 7'b0001000,
		PH_KEY   = 7'b0010000,
		PH_DATA  = 7'b0100000,
		PH_SKIP  = 7'b1000000
	} phase_t;

	phase_t      ph_q, ph_d;
	logic [4:0]  fo_q, fo_d;
	logic        mf_q, mf_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [63:0] rem_q, rem_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  pos_q, pos_d;

	logic [7:0]  b;
	logic        be;
	logic [7:0]  kb;
	logic        after_len;
	logic        hdr_done;
	logic        trunc_chk;
	logic [7:0]  r_data;
	logic        r_valid;
	logic        r_end;
	logic [1:0]  r_st;

	assign b  = in_word.rx_byte;
	assign be = in_word.buffer_end;
	// key byte for this payload position, first key byte is the top one
	assign kb = key_q[{~pos_q, 3'b000} +: 8];

	always_comb begin
		ph_d      = ph_q;
		fo_d      = fo_q;
		mf_d      = mf_q;
		cnt_d     = cnt_q;
		rem_d     = rem_q;
		key_d     = key_q;
		pos_d     = pos_q;
		after_len = 1'b0;
		hdr_done  = 1'b0;
		trunc_chk = 1'b0;
		emit      = 1'b0;
		r_data    = 8'd0;
		r_valid   = 1'b0;
		r_end     = 1'b0;
		r_st      = ST_OK;

		case (ph_q)
			PH_HDR1: begin
				mf_d  = b[7];
				cnt_d = 4'd0;
				rem_d = 64'd0;
				if (b[6:0] == LEN16_CODE) begin
					ph_d      = PH_EXT16;
					trunc_chk = 1'b1;
				end else if (b[6:0] == LEN64_CODE) begin
					ph_d      = PH_EXT64;
					trunc_chk = 1'b1;
				end else begin
					rem_d     = {57'd0, b[6:0]};
					after_len = 1'b1;
				end
			end
			PH_EXT16, PH_EXT64: begin
				rem_d = {rem_q[55:0], b};
				cnt_d = cnt_q + 4'd1;
				if (cnt_d >= ((ph_q == PH_EXT16) ? LEN16_BYTES : LEN64_BYTES)) begin
					after_len = 1'b1;
				end else begin
					trunc_chk = 1'b1;
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], b};
				cnt_d = cnt_q + 4'd1;
				if (cnt_d >= KEY_BYTES) begin
					hdr_done = 1'b1;
				end else begin
					trunc_chk = 1'b1;
				end
			end
			PH_DATA: begin
				pos_d   = pos_q + 2'd1;
				rem_d   = rem_q - 64'd1;
				emit    = 1'b1;
				r_data  = b ^ kb;
				r_valid = 1'b1;
				if (rem_q == 64'd1) begin
					r_end = 1'b1;
					ph_d  = PH_HDR0;
				end else if (be) begin
					r_end = 1'b1;
					r_st  = ST_TRUNC;
					ph_d  = PH_HDR0;
				end
			end
			PH_SKIP: begin
				if (rem_q != 64'd0) begin
					rem_d = rem_q - 64'd1;
				end
				if (rem_q <= 64'd1 || be) begin
					ph_d = PH_HDR0;
				end
			end
			default: begin
				// header byte zero, also taken for a corrupt phase code
				fo_d      = {b[7], b[3:0]};
				mf_d      = 1'b0;
				key_d     = 32'd0;
				pos_d     = 2'd0;
				rem_d     = 64'd0;
				cnt_d     = 4'd0;
				ph_d      = PH_HDR1;
				trunc_chk = 1'b1;
			end
		endcase

		// length known: key bytes next if masked
		if (after_len) begin
			if (mf_d) begin
				cnt_d = 4'd0;
				if (be) begin
					emit  = 1'b1;
					r_end = 1'b1;
					r_st  = ST_TRUNC;
					ph_d  = PH_HDR0;
				end else begin
					ph_d = PH_KEY;
				end
			end else begin
				hdr_done = 1'b1;
			end
		end

		// header complete
		if (hdr_done) begin
			if (rem_d > {1'b0, max_len}) begin
				emit  = 1'b1;
				r_end = 1'b1;
				r_st  = ST_TOO_LONG;
				ph_d  = be ? PH_HDR0 : PH_SKIP;
			end else if (rem_d == 64'd0) begin
				emit  = 1'b1;
				r_end = 1'b1;
				ph_d  = PH_HDR0;
			end else begin
				pos_d = 2'd0;
				if (be) begin
					emit  = 1'b1;
					r_end = 1'b1;
					r_st  = ST_TRUNC;
					ph_d  = PH_HDR0;
				end else begin
					ph_d = PH_DATA;
				end
			end
		end

		// buffer ran out mid header
		if (trunc_chk && be) begin
			emit  = 1'b1;
			r_end = 1'b1;
			r_st  = ST_TRUNC;
			ph_d  = PH_HDR0;
		end

		res.payload_byte = r_data;
		res.data_valid   = r_valid;
		res.frame_opcode = fo_d[3:0];
		res.frame_fin    = fo_d[4];
		res.frame_masked = mf_d;
		res.frame_end    = r_end;
		res.status       = r_st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_HDR0;
			fo_q  <= 5'd0;
			mf_q  <= 1'b0;
			cnt_q <= 4'd0;
			rem_q <= 64'd0;
			key_q <= 32'd0;
			pos_q <= 2'd0;
		end else if (step_en) begin
			ph_q  <= ph_d;
			fo_q  <= fo_d;
			mf_q  <= mf_d;
			cnt_q <= cnt_d;
			rem_q <= rem_d;
			key_q <= key_d;
			pos_q <= pos_d;
		end
	end

endmodule

@@ rtl/websocket_frame_deframer_unit.sv @@
// websocket frame deframer top level: input register, parser, result register
//
// channel   direction  handshake             word
// src       in         src_valid/src_stall   wsd_in_t  (rx_byte, buffer_end)
// res       out        res_valid/res_stall   wsd_out_t (payload, flags, status)
// cfg       in         cfg_we                63-bit max payload length
//
// one byte per clock sustained unless a result-making byte waits on a stalled res; a result goes through both registers
// byte goes into the input register, is parsed in one step, result lands in the output register
// reset clears parse state to header byte zero and the length limit to all ones
// a byte that gives no result is parsed even while the output register is stalled
// src_stall rises only when the input register holds a result-making byte and res is
// full and stalled
module websocket_frame_deframer_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_stall,
	input  wsd_pkg::wsd_in_t      src_word,
	output logic                  res_valid,
	input  logic                  res_stall,
	output wsd_pkg::wsd_out_t     res_word,
	input  logic                  cfg_we,
	input  logic [62:0]           cfg_wdata
);
	import wsd_pkg::*;

	// input register
	logic        v_s1;
	wsd_in_t     w_s1;

	// result register
	logic        v_s2;
	wsd_out_t    w_s2;

	// length limit
	logic [MAXLEN_W-1:0] max_len_q;

	wsd_out_t    step_res;
	logic        step_emit;
	logic        step_go;

	// parse when the byte makes no result or the result register has room
	assign step_go   = v_s1 && (!v_s2 || !res_stall || !step_emit);
	assign src_stall = v_s1 && !step_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= {MAXLEN_W{1'b1}};
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!src_stall) begin
			v_s1 <= src_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (!src_stall) begin
			w_s1 <= src_word;
		end
	end

	wsd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_go),
		.in_word (w_s1),
		.max_len (max_len_q),
		.res     (step_res),
		.emit    (step_emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (step_go && step_emit) begin
			v_s2 <= 1'b1;
		end else if (!res_stall) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && step_emit) begin
			w_s2 <= step_res;
		end
	end

	assign res_valid = v_s2;
	assign res_word  = w_s2;

	// a result without data always closes its frame
	a_nodata_end: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (w_s2.data_valid || w_s2.frame_end))
		else $error("result without data not marked frame end");

	// any error status closes the frame
	a_err_end: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && w_s2.status != ST_OK) |-> w_s2.frame_end)
		else $error("error status without frame end");

	// status is one of the defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (w_s2.status == ST_OK || w_s2.status == ST_TRUNC ||
		          w_s2.status == ST_TOO_LONG))
		else $error("undefined status code");

	// input side only backs up behind a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> (v_s2 && res_stall && step_emit))
		else $error("input stalled without a blocked result");

	// a held byte keeps its contents until parsed
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |=> (v_s1 && $stable(w_s1)))
		else $error("input register changed while stalled");

endmodule
